// File: hw/rtl/akp_pkg.sv
// Shared types and constants for the angular k-means pass block.
package akp_pkg;

  localparam int MaxClusters    = 8;
  localparam int MaxPassSamples = 4096;
  localparam int AngleW         = 13;
  localparam int CountW         = 13;
  localparam int SumW           = 25;
  localparam int IdxW           = 3;
  localparam int NumCfgW        = 4;

  localparam logic [AngleW-1:0] FullTurn = 13'd5760;
  localparam logic [AngleW-1:0] HalfTurn = 13'd2880;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic KIND_CLASS = 1'b0;
  localparam logic KIND_MEAN  = 1'b1;

  localparam logic REG_NUM_CLUSTERS  = 1'b0;
  localparam logic REG_UPDATE_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACC,
    ST_CLASS,
    ST_UPD,
    ST_DIVW,
    ST_MEAN
  } akp_state_t;

endpackage

// File: hw/rtl/akp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module akp_div
  import akp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SumW-1:0]   num,
  input  logic [CountW:0]   den,
  output logic              done,
  output logic [SumW-1:0]   quot
);

  logic [SumW-1:0]  q;
  logic [CountW:0]  rem;
  logic [CountW:0]  dv;
  logic [4:0]       cnt;
  logic             busy;
  logic [CountW+1:0] trial;
  logic [CountW+1:0] shifted;

  always_comb begin
    shifted = {rem, q[SumW-1]};
    trial   = shifted - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(SumW - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      if (!trial[CountW+1]) begin
        rem <= trial[CountW:0];
        q   <= {q[SumW-2:0], 1'b1};
      end else begin
        rem <= shifted[CountW:0];
        q   <= {q[SumW-2:0], 1'b0};
      end
    end
  end

  assign quot = q;

endmodule

// File: hw/rtl/angular_kmeans_pass_core.sv
// Top level of the angular k-means pass block: sequencer, cluster state and output register.
//
// Channel  Dir  Handshake           Contents
// s_       in   s_tvalid/s_tready   tuser=cmd, tdata=cluster_sel,angle, tlast=last_sample
// m_       out  m_tvalid/m_tready   tuser=kind, tdata=cluster,mean_angle,member_count,
//                                   tlast=last_result
// cfg_     in   cfg_we              cfg_addr selects the register, cfg_wdata is the value
//
// A mean load is written in the idle state. A sample steps through the active clusters,
// one distance compare per cluster through the shared compare unit.
// A last sample then adds, per cluster, a mean result and a pass through the serial divider
// when the mean is updated. Reset is synchronous and clears all control and cluster state.
// A stalled output only holds the sequencer when it has a new result to place.
module angular_kmeans_pass_core
  import akp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // cluster_sel[2:0], angle[15:3]
  input  logic               s_tuser,   // cmd
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,   // cluster[2:0], mean_angle[15:3], member_count[28:16]
  output logic               m_tuser,   // kind
  output logic               m_tlast,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [NumCfgW-1:0] cfg_wdata
);

  akp_state_t state, state_next;

  logic [NumCfgW-1:0] num_clusters;
  logic               update_enable;

  logic [AngleW-1:0] means  [MaxClusters];
  logic [SumW-1:0]   sums   [MaxClusters];
  logic [CountW-1:0] counts [MaxClusters];

  logic [AngleW-1:0] smp;
  logic              smp_last;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   best;
  logic [AngleW-1:0] best_d;
  logic [IdxW-1:0]   last_idx;

  logic [AngleW-1:0] in_angle;
  logic [AngleW-1:0] in_wrapped;
  logic [AngleW-1:0] diff;
  logic [AngleW-1:0] cur_dist;
  logic              out_free;
  logic              accept;

  logic              div_start;
  logic              div_done;
  logic [SumW-1:0]   quot;
  logic [SumW-1:0]   div_num;
  logic [CountW:0]   div_den;

  logic [2:0]        o_cluster;
  logic [AngleW-1:0] o_mean;
  logic [CountW-1:0] o_count;

  assign in_angle   = s_tdata[15:3];
  assign in_wrapped = (in_angle >= FullTurn) ? in_angle - FullTurn : in_angle;
  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    if (num_clusters == '0) begin
      last_idx = '0;
    end else if (num_clusters > NumCfgW'(MaxClusters)) begin
      last_idx = IdxW'(MaxClusters - 1);
    end else begin
      last_idx = IdxW'(num_clusters - NumCfgW'(1));
    end
  end

  always_comb begin
    diff     = (smp >= means[idx]) ? smp - means[idx] : means[idx] - smp;
    cur_dist = (diff > HalfTurn) ? FullTurn - diff : diff;
  end

  assign div_num = SumW'(means[idx]) + sums[idx];
  assign div_den = {1'b0, counts[idx]} + (CountW+1)'(1);

  akp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && s_tuser == CMD_SAMPLE) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (idx == last_idx) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: state_next = ST_CLASS;
      ST_CLASS: begin
        if (out_free) begin
          state_next = smp_last ? ST_UPD : ST_IDLE;
        end
      end
      ST_UPD: begin
        if (update_enable && counts[idx] != '0) begin
          div_start  = 1'b1;
          state_next = ST_DIVW;
        end else begin
          state_next = ST_MEAN;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (out_free) begin
          state_next = (idx == last_idx) ? ST_IDLE : ST_UPD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters  <= NumCfgW'(1);
      update_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUM_CLUSTERS:  num_clusters  <= cfg_wdata;
        REG_UPDATE_ENABLE: update_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      best     <= '0;
      best_d   <= '0;
      smp      <= '0;
      smp_last <= 1'b0;
      for (int k = 0; k < MaxClusters; k++) begin
        means[k]  <= '0;
        sums[k]   <= '0;
        counts[k] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == CMD_LOAD) begin
              means[s_tdata[2:0]] <= in_wrapped;
            end else begin
              smp      <= in_wrapped;
              smp_last <= s_tlast;
              idx      <= '0;
            end
          end
        end
        ST_CMP: begin
          if (idx == '0 || cur_dist < best_d) begin
            best   <= idx;
            best_d <= cur_dist;
          end
          idx <= idx + IdxW'(1);
        end
        ST_ACC: begin
          if (counts[best] < CountW'(MaxPassSamples)) begin
            counts[best] <= counts[best] + CountW'(1);
            sums[best]   <= sums[best] + SumW'(smp);
          end
        end
        ST_CLASS: begin
          if (out_free) begin
            idx <= '0;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            means[idx] <= quot[AngleW-1:0];
          end
        end
        ST_MEAN: begin
          if (out_free) begin
            if (idx == last_idx) begin
              for (int k = 0; k < MaxClusters; k++) begin
                sums[k]   <= '0;
                counts[k] <= '0;
              end
            end else begin
              idx <= idx + IdxW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_CLASS || state == ST_MEAN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLASS && out_free) begin
      m_tuser   <= KIND_CLASS;
      o_cluster <= best;
      o_mean    <= '0;
      o_count   <= counts[best];
      m_tlast   <= 1'b0;
    end else if (state == ST_MEAN && out_free) begin
      m_tuser   <= KIND_MEAN;
      o_cluster <= idx;
      o_mean    <= means[idx];
      o_count   <= counts[idx];
      m_tlast   <= (idx == last_idx);
    end
  end

  assign m_tdata = {3'b000, o_count, o_mean, o_cluster};

  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> idx <= last_idx)
    else $error("compare index beyond active clusters");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVW)
    else $error("divider finished outside the wait state");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLASS |-> counts[best] <= CountW'(MaxPassSamples))
    else $error("cluster count above pass limit");

  a_pass_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MEAN && out_free && idx == last_idx) |=> counts[0] == '0)
    else $error("counts not cleared at end of pass");

endmodule
